// ----- rtl/tclw_pkg.sv -----
// -----------------------------------------------------------------------------
// tclw_pkg
// Shared types and constants of the text cell layout unit: channel payloads,
// configuration set, queue entry and the register index and status codes.
// -----------------------------------------------------------------------------
package tclw_pkg;

   // Default character limit per frame.
   localparam int MAX_CHARS_DEF = 1024;

   // Depth of the queue between front and back.
   localparam int QUEUE_DEPTH = 4;

   // Character codes with a fixed meaning.
   localparam logic [7:0] CH_NEWLINE  = 8'd10;
   localparam logic [7:0] CH_QUESTION = 8'd63;

   // Register reset values.
   localparam logic [15:0] RST_WINDOW_WIDTH    = 16'd1280;
   localparam logic [15:0] RST_WINDOW_HEIGHT   = 16'd720;
   localparam logic [7:0]  RST_MARGIN          = 8'd10;
   localparam logic [7:0]  RST_CELL_WIDTH      = 8'd10;
   localparam logic [7:0]  RST_CELL_HEIGHT     = 8'd20;
   localparam logic [7:0]  RST_LINE_GAP        = 8'd2;
   localparam logic [7:0]  RST_FIRST_PRINTABLE = 8'd32;
   localparam logic [7:0]  RST_LAST_PRINTABLE  = 8'd126;

   // Derived values matching the register reset values.
   localparam logic [15:0] RST_DRAW_WIDTH  = RST_WINDOW_WIDTH - 16'(2 * RST_MARGIN);
   localparam logic [15:0] RST_DRAW_HEIGHT = RST_WINDOW_HEIGHT - 16'(2 * RST_MARGIN);
   localparam logic [8:0]  RST_LINE_STEP   = 9'(RST_CELL_HEIGHT) + 9'(RST_LINE_GAP);

   // Configuration register indexes.
   localparam logic [2:0] CSR_WINDOW_WIDTH    = 3'd0;
   localparam logic [2:0] CSR_WINDOW_HEIGHT   = 3'd1;
   localparam logic [2:0] CSR_MARGIN          = 3'd2;
   localparam logic [2:0] CSR_CELL_WIDTH      = 3'd3;
   localparam logic [2:0] CSR_CELL_HEIGHT     = 3'd4;
   localparam logic [2:0] CSR_LINE_GAP        = 3'd5;
   localparam logic [2:0] CSR_FIRST_PRINTABLE = 3'd6;
   localparam logic [2:0] CSR_LAST_PRINTABLE  = 3'd7;

   // Result status codes.
   typedef enum logic [1:0] {
      ST_DRAWN   = 2'd0,
      ST_NEWLINE = 2'd1,
      ST_DROPPED = 2'd2,
      ST_CLEARED = 2'd3
   } status_type;

   // Item class decided by the front.
   typedef enum logic [1:0] {
      KIND_CLEAR   = 2'd0,
      KIND_LIMIT   = 2'd1,
      KIND_NEWLINE = 2'd2,
      KIND_CHAR    = 2'd3
   } kind_type;

   // Input beat.
   typedef struct packed {
      logic        action;
      logic [7:0]  char_code;
      logic [31:0] color;
   } req_type;

   // Result beat.
   typedef struct packed {
      status_type  status;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  glyph;
      logic [31:0] cell_color;
      logic [9:0]  slot_index;
   } rsp_type;

   // Configuration set.
   typedef struct packed {
      logic [15:0] window_width;
      logic [15:0] window_height;
      logic [7:0]  margin;
      logic [7:0]  cell_width;
      logic [7:0]  cell_height;
      logic [7:0]  line_gap;
      logic [7:0]  first_printable;
      logic [7:0]  last_printable;
   } cfg_type;

   // Classified item as it travels through the queue.
   typedef struct packed {
      kind_type    kind;
      logic [7:0]  glyph;
      logic [31:0] color;
   } cmd_type;

endpackage

// ----- rtl/tclw_front.sv -----
// -----------------------------------------------------------------------------
// tclw_front
// Accepts input beats, enforces the per-frame character limit and classifies
// each item for the back, computing its glyph index on the way.
// -----------------------------------------------------------------------------
module tclw_front #(
   parameter int MAX_CHARS = tclw_pkg::MAX_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tclw_pkg::req_type req_payload,
   input  tclw_pkg::cfg_type cfg,
   input  logic              queue_full,
   output logic              push,
   output tclw_pkg::cmd_type push_data
);

   localparam int CNT_W = $clog2(MAX_CHARS + 1);

   logic [CNT_W-1:0] accepted_ff;
   logic [CNT_W-1:0] accepted_in;
   logic             at_limit;
   logic             printable;
   logic [7:0]       code_eff;

   // The queue decides whether a beat can be taken.
   assign req_stall = queue_full;
   assign push      = req_valid && !queue_full;
   assign at_limit  = (accepted_ff == CNT_W'(MAX_CHARS));

   // Codes without a glyph are shown as a question mark.
   assign printable = (req_payload.char_code >= cfg.first_printable) &&
                      (req_payload.char_code <= cfg.last_printable);
   assign code_eff  = printable ? req_payload.char_code : tclw_pkg::CH_QUESTION;

   // Classify the item and count it against the frame limit.
   always_comb begin
      accepted_in     = accepted_ff;
      push_data.glyph = code_eff - cfg.first_printable;
      push_data.color = req_payload.color;
      priority if (req_payload.action) begin
         push_data.kind = tclw_pkg::KIND_CLEAR;
         accepted_in    = '0;
      end else if (at_limit) begin
         push_data.kind = tclw_pkg::KIND_LIMIT;
      end else begin
         accepted_in = accepted_ff + CNT_W'(1);
         if (req_payload.char_code == tclw_pkg::CH_NEWLINE) begin
            push_data.kind = tclw_pkg::KIND_NEWLINE;
         end else begin
            push_data.kind = tclw_pkg::KIND_CHAR;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_ff <= '0;
      end else if (push) begin
         accepted_ff <= accepted_in;
      end
   end

   // The count never passes the limit.
   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      accepted_ff <= CNT_W'(MAX_CHARS))
      else $error("accepted count above limit");

   // A clear restarts the count.
   a_clear_restarts: assert property (@(posedge clock) disable iff (reset)
      push && req_payload.action |=> accepted_ff == '0)
      else $error("clear did not restart count");

   // A beat taken at the limit is not counted.
   a_limit_holds: assert property (@(posedge clock) disable iff (reset)
      push && !req_payload.action && at_limit |=> accepted_ff == CNT_W'(MAX_CHARS))
      else $error("count moved at limit");

endmodule

// ----- rtl/tclw_queue.sv -----
// -----------------------------------------------------------------------------
// tclw_queue
// Short first-in first-out queue of classified items between front and back.
// -----------------------------------------------------------------------------
module tclw_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  tclw_pkg::cmd_type push_data,
   output logic              full,
   input  logic              pop,
   output logic              head_valid,
   output tclw_pkg::cmd_type head
);

   localparam int DEPTH = tclw_pkg::QUEUE_DEPTH;
   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   tclw_pkg::cmd_type entry_ff [DEPTH];
   logic [PTR_W-1:0]  wr_ptr_ff;
   logic [PTR_W-1:0]  rd_ptr_ff;
   logic [CNT_W-1:0]  count_ff;
   logic [CNT_W-1:0]  count_in;

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head_valid = (count_ff != '0);
   assign head       = entry_ff[rd_ptr_ff];

   // Occupancy follows pushes and pops.
   always_comb begin
      count_in = count_ff;
      priority if (push && !pop) begin
         count_in = count_ff + CNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_W'(1);
      end
   end

   // Pointers and occupancy.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
      end
   end

   // Entry storage.
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // The front never pushes into a full queue, and the back never pops an empty one.
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("push into full queue");

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !head_valid |-> !pop)
      else $error("pop from empty queue");

   a_count_tracks: assert property (@(posedge clock) disable iff (reset)
      push && !pop && !full |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("occupancy did not follow push");

endmodule

// ----- rtl/tclw_back.sv -----
// -----------------------------------------------------------------------------
// tclw_back
// Carries out classified items: keeps the pen, wraps at the right edge, stops
// at the bottom edge and places each result in the output register.
// -----------------------------------------------------------------------------
module tclw_back (
   input  logic              clock,
   input  logic              reset,
   input  tclw_pkg::cfg_type cfg,
   input  logic              head_valid,
   input  tclw_pkg::cmd_type head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tclw_pkg::rsp_type rsp_payload
);

   // Drawable extent and line step, taken from the configuration.
   logic [15:0] draw_width_ff;
   logic [15:0] draw_height_ff;
   logic [8:0]  line_step_ff;
   logic [15:0] twice_margin;

   // Pen and frame state.
   logic [15:0] pen_x_ff, pen_x_in;
   logic [15:0] pen_y_ff, pen_y_in;
   logic [9:0]  drawn_ff, drawn_in;
   logic        area_full_ff, area_full_in;

   // Result register.
   logic              rsp_valid_ff;
   tclw_pkg::rsp_type rsp_ff, rsp_in;

   logic [15:0] margin_x;
   logic [16:0] adv_y;
   logic        wrap;
   logic [16:0] char_y;
   logic [15:0] char_x;
   logic        nl_full;
   logic        char_full;

   // Extents are registered; the user must make configuration changes only while the unit is idle, unchecked here.
   assign twice_margin = {7'd0, cfg.margin, 1'b0};

   always_ff @(posedge clock) begin
      if (reset) begin
         draw_width_ff  <= tclw_pkg::RST_DRAW_WIDTH;
         draw_height_ff <= tclw_pkg::RST_DRAW_HEIGHT;
         line_step_ff   <= tclw_pkg::RST_LINE_STEP;
      end else begin
         draw_width_ff  <= (cfg.window_width > twice_margin) ?
                           cfg.window_width - twice_margin : '0;
         draw_height_ff <= (cfg.window_height > twice_margin) ?
                           cfg.window_height - twice_margin : '0;
         line_step_ff   <= {1'b0, cfg.cell_height} + {1'b0, cfg.line_gap};
      end
   end

   // Take an item whenever the result register is free or being emptied.
   assign pop = head_valid && (!rsp_valid_ff || !rsp_stall);

   // Edge checks on the current pen.
   assign margin_x  = {8'd0, cfg.margin};
   assign adv_y     = {1'b0, pen_y_ff} + {8'd0, line_step_ff};
   assign wrap      = ({1'b0, pen_x_ff} + {9'd0, cfg.cell_width}) >= {1'b0, draw_width_ff};
   assign char_y    = wrap ? adv_y : {1'b0, pen_y_ff};
   assign char_x    = wrap ? margin_x : pen_x_ff;
   assign nl_full   = ({1'b0, adv_y} + {10'd0, cfg.cell_height}) >= {2'd0, draw_height_ff};
   assign char_full = ({1'b0, char_y} + {10'd0, cfg.cell_height}) >= {2'd0, draw_height_ff};

   // Next pen state and result for the item at the head of the queue.
   always_comb begin
      pen_x_in     = pen_x_ff;
      pen_y_in     = pen_y_ff;
      drawn_in     = drawn_ff;
      area_full_in = area_full_ff;
      rsp_in       = '0;
      rsp_in.status = tclw_pkg::ST_DROPPED;
      unique case (head.kind)
         tclw_pkg::KIND_CLEAR: begin
            pen_x_in      = margin_x;
            pen_y_in      = margin_x;
            drawn_in      = '0;
            area_full_in  = 1'b0;
            rsp_in.status = tclw_pkg::ST_CLEARED;
         end
         tclw_pkg::KIND_LIMIT: begin
            rsp_in.status = tclw_pkg::ST_DROPPED;
         end
         tclw_pkg::KIND_NEWLINE: begin
            if (!area_full_ff) begin
               pen_x_in      = margin_x;
               pen_y_in      = adv_y[15:0];
               area_full_in  = nl_full;
               rsp_in.status = tclw_pkg::ST_NEWLINE;
            end
         end
         tclw_pkg::KIND_CHAR: begin
            if (!area_full_ff) begin
               pen_x_in = char_x;
               pen_y_in = char_y[15:0];
               if (char_full) begin
                  area_full_in = 1'b1;
               end else begin
                  pen_x_in          = char_x + {8'd0, cfg.cell_width};
                  drawn_in          = drawn_ff + 10'd1;
                  rsp_in.status     = tclw_pkg::ST_DRAWN;
                  rsp_in.pos_x      = char_x;
                  rsp_in.pos_y      = char_y[15:0];
                  rsp_in.glyph      = head.glyph;
                  rsp_in.cell_color = head.color;
                  rsp_in.slot_index = drawn_ff;
               end
            end
         end
      endcase
   end

   // Pen state and result valid.
   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff     <= {8'd0, tclw_pkg::RST_MARGIN};
         pen_y_ff     <= {8'd0, tclw_pkg::RST_MARGIN};
         drawn_ff     <= '0;
         area_full_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop) begin
            pen_x_ff     <= pen_x_in;
            pen_y_ff     <= pen_y_in;
            drawn_ff     <= drawn_in;
            area_full_ff <= area_full_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // A clear leaves an empty, drawable frame.
   a_clear_state: assert property (@(posedge clock) disable iff (reset)
      pop && head.kind == tclw_pkg::KIND_CLEAR |=> !area_full_ff && drawn_ff == '0)
      else $error("clear left stale frame state");

   // Once the area is full no character is drawn.
   a_full_drops: assert property (@(posedge clock) disable iff (reset)
      pop && area_full_ff && head.kind == tclw_pkg::KIND_CHAR |=>
      rsp_ff.status == tclw_pkg::ST_DROPPED)
      else $error("character drawn in full area");

   // Every item taken shows up as a result.
   a_pop_shows: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid_ff)
      else $error("taken item produced no result");

   // The slot index advances only with a drawn cell.
   a_slot_advance: assert property (@(posedge clock) disable iff (reset)
      pop && head.kind != tclw_pkg::KIND_CLEAR && rsp_in.status != tclw_pkg::ST_DRAWN
      |=> drawn_ff == $past(drawn_ff))
      else $error("slot index moved without a drawn cell");

endmodule

// ----- rtl/text_cell_layout_with_wrap_unit.sv -----
// -----------------------------------------------------------------------------
// text_cell_layout_with_wrap_unit
// Lays out a character stream as fixed-size glyph cells with wrap and clip.
// -----------------------------------------------------------------------------
// The unit takes one character or clear beat per cycle while its input is not
// stalled, and returns exactly one result beat for each, in order. A front stage
// counts characters against the frame limit and computes the glyph index, a
// four-entry queue decouples it from the back stage, and the back stage updates
// the pen and loads the output register, so the sustained rate is one item per
// cycle while the output does not stall. An accepted beat is held in a queue
// entry and then in the output register before its result is shown. Drawable
// extents are recomputed into registers from the configuration registers, so the
// first item should follow a write by at least one cycle.
module text_cell_layout_with_wrap_unit #(
   parameter int MAX_CHARS = tclw_pkg::MAX_CHARS_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tclw_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tclw_pkg::rsp_type rsp_payload,
   input  logic              csr_write,
   input  logic [2:0]        csr_index,
   input  logic [15:0]       csr_wdata
);

   tclw_pkg::cfg_type cfg_ff;
   tclw_pkg::cmd_type push_data;
   tclw_pkg::cmd_type head;
   logic              push;
   logic              queue_full;
   logic              pop;
   logic              head_valid;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_width    <= tclw_pkg::RST_WINDOW_WIDTH;
         cfg_ff.window_height   <= tclw_pkg::RST_WINDOW_HEIGHT;
         cfg_ff.margin          <= tclw_pkg::RST_MARGIN;
         cfg_ff.cell_width      <= tclw_pkg::RST_CELL_WIDTH;
         cfg_ff.cell_height     <= tclw_pkg::RST_CELL_HEIGHT;
         cfg_ff.line_gap        <= tclw_pkg::RST_LINE_GAP;
         cfg_ff.first_printable <= tclw_pkg::RST_FIRST_PRINTABLE;
         cfg_ff.last_printable  <= tclw_pkg::RST_LAST_PRINTABLE;
      end else if (csr_write) begin
         unique case (csr_index)
            tclw_pkg::CSR_WINDOW_WIDTH:    cfg_ff.window_width    <= csr_wdata;
            tclw_pkg::CSR_WINDOW_HEIGHT:   cfg_ff.window_height   <= csr_wdata;
            tclw_pkg::CSR_MARGIN:          cfg_ff.margin          <= csr_wdata[7:0];
            tclw_pkg::CSR_CELL_WIDTH:      cfg_ff.cell_width      <= csr_wdata[7:0];
            tclw_pkg::CSR_CELL_HEIGHT:     cfg_ff.cell_height     <= csr_wdata[7:0];
            tclw_pkg::CSR_LINE_GAP:        cfg_ff.line_gap        <= csr_wdata[7:0];
            tclw_pkg::CSR_FIRST_PRINTABLE: cfg_ff.first_printable <= csr_wdata[7:0];
            tclw_pkg::CSR_LAST_PRINTABLE:  cfg_ff.last_printable  <= csr_wdata[7:0];
         endcase
      end
   end

   // Front: accept and classify.
   tclw_front #(
      .MAX_CHARS (MAX_CHARS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .queue_full  (queue_full),
      .push        (push),
      .push_data   (push_data)
   );

   // Queue between front and back.
   tclw_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head       (head)
   );

   // Back: pen update and result register.
   tclw_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .head_valid  (head_valid),
      .head        (head),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

endmodule

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the text cell layout unit.
// ----------------------------------------------------------------------------
// Character and clear beats go in over the valid/stall channel. A behavioral
// pen model predicts the result beat of every accepted beat, and each returned
// beat is compared field by field with the oldest prediction. Directed tests
// cover the field extremes, wrap at the right edge, clip at the bottom edge,
// glyph index wrap and the per-frame character limit. A long back-pressure
// stretch fills the unit. A random stream then runs under several register
// settings and idle patterns.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CHAR_LIMIT    = tclw_pkg::MAX_CHARS_DEF;
   localparam int IDLE_LIMIT    = 2000;
   localparam int RANDOM_BEATS  = 120;
   localparam int RANDOM_PHASES = 8;
   localparam int SETTLE_CYCLES = 6;
   localparam int HOLD_CYCLES   = 300;

   logic              clock       = 1'b0;
   logic              reset       = 1'b1;
   logic              req_valid   = 1'b0;
   logic              req_stall;
   tclw_pkg::req_type req_payload = '0;
   logic              rsp_valid;
   logic              rsp_stall   = 1'b0;
   tclw_pkg::rsp_type rsp_payload;
   logic              csr_write   = 1'b0;
   logic [2:0]        csr_index   = '0;
   logic [15:0]       csr_wdata   = '0;

   // Pen model state and its own copy of the registers.
   tclw_pkg::cfg_type layout_cfg;
   logic [15:0]       pen_x;
   logic [15:0]       pen_y;
   int                chars_in_frame;
   int                cells_in_frame;
   bit                text_area_full;

   // Predicted result beats, oldest first.
   tclw_pkg::rsp_type pending_cells[$];

   int send_idle_pct    = 0;
   int stall_pct        = 0;
   int hold_request     = 0;
   int quiet_cycles     = 0;
   int error_count      = 0;
   int beats_sent       = 0;
   int settings_applied = 0;
   int status_seen[4]   = '{default: 0};

   text_cell_layout_with_wrap_unit #(.MAX_CHARS(CHAR_LIMIT)) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   // Free-running clock, 10 ns period.
   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Pen model
   // ---------------------------------------------------------------------

   // A clear puts the pen back at the current margin and opens a new frame.
   function automatic void reset_pen_model();
      pen_x          = 16'(layout_cfg.margin);
      pen_y          = 16'(layout_cfg.margin);
      chars_in_frame = 0;
      cells_in_frame = 0;
      text_area_full = 1'b0;
   endfunction

   // Window size less both margins, never below zero.
   function automatic logic [31:0] drawable_extent(logic [15:0] window);
      logic [31:0] twice;
      twice = 32'(layout_cfg.margin) * 2;
      return (32'(window) > twice) ? 32'(window) - twice : 32'd0;
   endfunction

   // Works out the result beat of one accepted beat and advances the pen.
   function automatic tclw_pkg::rsp_type predict_layout(tclw_pkg::req_type beat);
      tclw_pkg::rsp_type outcome;
      logic [31:0]       draw_w;
      logic [31:0]       draw_h;
      logic [31:0]       next_y;
      logic [31:0]       line_step;
      logic [7:0]        code;
      outcome = '0;
      if (beat.action) begin
         reset_pen_model();
         outcome.status = tclw_pkg::ST_CLEARED;
         return outcome;
      end
      // Beyond the limit nothing is counted; a full area still counts.
      outcome.status = tclw_pkg::ST_DROPPED;
      if (chars_in_frame >= CHAR_LIMIT) return outcome;
      chars_in_frame++;
      if (text_area_full) return outcome;
      draw_w    = drawable_extent(layout_cfg.window_width);
      draw_h    = drawable_extent(layout_cfg.window_height);
      line_step = 32'(layout_cfg.cell_height) + 32'(layout_cfg.line_gap);
      // A newline only moves the pen; the line it opens may already be clipped.
      if (beat.char_code == tclw_pkg::CH_NEWLINE) begin
         next_y = 32'(pen_y) + line_step;
         pen_x  = 16'(layout_cfg.margin);
         pen_y  = next_y[15:0];
         if (next_y + 32'(layout_cfg.cell_height) >= draw_h) text_area_full = 1'b1;
         outcome.status = tclw_pkg::ST_NEWLINE;
         return outcome;
      end
      // Wrap first, then clip against the bottom edge.
      next_y = 32'(pen_y);
      if (32'(pen_x) + 32'(layout_cfg.cell_width) >= draw_w) begin
         pen_x  = 16'(layout_cfg.margin);
         next_y = 32'(pen_y) + line_step;
      end
      pen_y = next_y[15:0];
      if (next_y + 32'(layout_cfg.cell_height) >= draw_h) begin
         text_area_full = 1'b1;
         return outcome;
      end
      code = beat.char_code;
      if (code < layout_cfg.first_printable || code > layout_cfg.last_printable) begin
         code = tclw_pkg::CH_QUESTION;
      end
      outcome.status     = tclw_pkg::ST_DRAWN;
      outcome.pos_x      = pen_x;
      outcome.pos_y      = pen_y;
      outcome.glyph      = code - layout_cfg.first_printable;
      outcome.cell_color = beat.color;
      outcome.slot_index = 10'(cells_in_frame);
      pen_x              = pen_x + 16'(layout_cfg.cell_width);
      cells_in_frame++;
      return outcome;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   function automatic tclw_pkg::req_type char_beat(logic action, logic [7:0] code,
                                                   logic [31:0] color);
      tclw_pkg::req_type beat;
      beat.action    = action;
      beat.char_code = code;
      beat.color     = color;
      return beat;
   endfunction

   // Mostly printable text with some newlines, clears and arbitrary bytes.
   function automatic tclw_pkg::req_type random_text_beat();
      tclw_pkg::req_type beat;
      int                pick;
      pick           = $urandom_range(99);
      beat.action    = (pick < 4);
      beat.char_code = 8'($urandom_range(255));
      beat.color     = $urandom();
      if (pick >= 4 && pick < 14) begin
         beat.char_code = tclw_pkg::CH_NEWLINE;
      end else if (pick >= 14 && pick < 84 &&
                   layout_cfg.first_printable <= layout_cfg.last_printable) begin
         beat.char_code = 8'($urandom_range(layout_cfg.last_printable,
                                            layout_cfg.first_printable));
      end
      return beat;
   endfunction

   // Small layouts so wraps and clips come often, with the odd extreme field.
   function automatic tclw_pkg::cfg_type random_settings();
      tclw_pkg::cfg_type c;
      c.window_width    = 16'($urandom_range(400));
      c.window_height   = 16'($urandom_range(300));
      c.margin          = 8'($urandom_range(40));
      c.cell_width      = 8'($urandom_range(40, 1));
      c.cell_height     = 8'($urandom_range(30, 1));
      c.line_gap        = 8'($urandom_range(8));
      c.first_printable = 8'($urandom_range(70));
      c.last_printable  = 8'($urandom_range(255, 60));
      if ($urandom_range(5) == 0) c.window_width    = 16'hFFFF;
      if ($urandom_range(5) == 0) c.window_height   = 16'hFFFF;
      if ($urandom_range(7) == 0) c.margin          = 8'hFF;
      if ($urandom_range(7) == 0) c.cell_width      = 8'hFF;
      if ($urandom_range(7) == 0) c.cell_height     = 8'hFF;
      if ($urandom_range(7) == 0) c.line_gap        = 8'hFF;
      if ($urandom_range(7) == 0) c.first_printable = 8'hFF;
      if ($urandom_range(7) == 0) c.last_printable  = 8'h00;
      return c;
   endfunction

   // The upper byte of an 8-bit register write carries random junk.
   function automatic logic [15:0] byte_write(logic [7:0] value);
      return {8'($urandom_range(255)), value};
   endfunction

   // Offers one beat, with random idle cycles ahead of it, and records its
   // prediction once the unit takes it.
   task automatic send_beat(tclw_pkg::req_type beat);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_cells.push_back(predict_layout(beat));
      beats_sent++;
   endtask

   // Holds the sender until every predicted beat has come back.
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (pending_cells.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [15:0] value);
      csr_write <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      case (index)
         tclw_pkg::CSR_WINDOW_WIDTH:    layout_cfg.window_width    = value;
         tclw_pkg::CSR_WINDOW_HEIGHT:   layout_cfg.window_height   = value;
         tclw_pkg::CSR_MARGIN:          layout_cfg.margin          = value[7:0];
         tclw_pkg::CSR_CELL_WIDTH:      layout_cfg.cell_width      = value[7:0];
         tclw_pkg::CSR_CELL_HEIGHT:     layout_cfg.cell_height     = value[7:0];
         tclw_pkg::CSR_LINE_GAP:        layout_cfg.line_gap        = value[7:0];
         tclw_pkg::CSR_FIRST_PRINTABLE: layout_cfg.first_printable = value[7:0];
         tclw_pkg::CSR_LAST_PRINTABLE:  layout_cfg.last_printable  = value[7:0];
         default: ;
      endcase
   endtask

   // Writes the whole register set while the unit is idle.
   task automatic apply_settings(tclw_pkg::cfg_type c);
      wait_for_results();
      write_register(tclw_pkg::CSR_WINDOW_WIDTH,    c.window_width);
      write_register(tclw_pkg::CSR_WINDOW_HEIGHT,   c.window_height);
      write_register(tclw_pkg::CSR_MARGIN,          byte_write(c.margin));
      write_register(tclw_pkg::CSR_CELL_WIDTH,      byte_write(c.cell_width));
      write_register(tclw_pkg::CSR_CELL_HEIGHT,     byte_write(c.cell_height));
      write_register(tclw_pkg::CSR_LINE_GAP,        byte_write(c.line_gap));
      write_register(tclw_pkg::CSR_FIRST_PRINTABLE, byte_write(c.first_printable));
      write_register(tclw_pkg::CSR_LAST_PRINTABLE,  byte_write(c.last_printable));
      csr_write <= 1'b0;
      // Derived extents settle in their registers after the last write.
      repeat (2) @(posedge clock);
      settings_applied++;
   endtask

   // ---------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------

   // Reset settings: printable extremes, unprintable codes, newline, clear.
   task automatic test_reset_defaults();
      send_beat(char_beat(1'b0, 8'd65,  32'hFFFF_FFFF));
      send_beat(char_beat(1'b0, 8'd32,  32'h0000_0000));
      send_beat(char_beat(1'b0, 8'd126, 32'h1234_5678));
      send_beat(char_beat(1'b0, 8'd0,   32'hA5A5_A5A5));
      send_beat(char_beat(1'b0, 8'd255, 32'h5A5A_5A5A));
      send_beat(char_beat(1'b0, tclw_pkg::CH_NEWLINE, 32'hFFFF_FFFF));
      send_beat(char_beat(1'b1, 8'd0,   32'h0));
      wait_for_results();
   endtask

   // One cell per line and two lines: wrap, bottom clip from a cell and
   // from a newline, drops while full, and a glyph index that wraps.
   task automatic test_wrap_and_clip();
      apply_settings('{16'd50, 16'd50, 8'd5, 8'd20, 8'd10, 8'd3, 8'd64, 8'd90});
      send_beat(char_beat(1'b1, 8'd0,   32'h0));
      send_beat(char_beat(1'b0, 8'd65,  32'hDEAD_BEEF));
      send_beat(char_beat(1'b0, 8'd200, 32'h0BAD_F00D));
      send_beat(char_beat(1'b0, 8'd90,  32'h1111_1111));
      send_beat(char_beat(1'b0, 8'd66,  32'h2222_2222));
      send_beat(char_beat(1'b0, tclw_pkg::CH_NEWLINE, 32'h0));
      send_beat(char_beat(1'b1, 8'd0,   32'h0));
      send_beat(char_beat(1'b0, tclw_pkg::CH_NEWLINE, 32'h0));
      send_beat(char_beat(1'b0, tclw_pkg::CH_NEWLINE, 32'h0));
      send_beat(char_beat(1'b0, 8'd67,  32'h3333_3333));
      send_beat(char_beat(1'b1, 8'd0,   32'h0));
      wait_for_results();
   endtask

   // Window smaller than both margins, then the largest window and cells
   // with every code printable.
   task automatic test_register_extremes();
      apply_settings('{16'd0, 16'd0, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd0});
      send_beat(char_beat(1'b1, 8'd0,  32'h0));
      send_beat(char_beat(1'b0, 8'd65, 32'hFFFF_FFFF));
      send_beat(char_beat(1'b1, 8'd0,  32'h0));
      apply_settings('{16'hFFFF, 16'hFFFF, 8'd0, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255});
      send_beat(char_beat(1'b1, 8'd0,   32'h0));
      send_beat(char_beat(1'b0, 8'd0,   32'h8000_0001));
      send_beat(char_beat(1'b0, 8'd255, 32'h7FFF_FFFE));
      send_beat(char_beat(1'b0, tclw_pkg::CH_NEWLINE, 32'h0));
      send_beat(char_beat(1'b0, 8'd127, 32'hFFFF_FFFF));
      send_beat(char_beat(1'b1, 8'd0,   32'h0));
      wait_for_results();
   endtask

   // One frame that draws up to the character limit and drops past it.
   task automatic test_frame_limit();
      apply_settings('{16'hFFFF, 16'hFFFF, 8'd0, 8'd1, 8'd1, 8'd0, 8'd32, 8'd126});
      send_idle_pct = 25;
      stall_pct     = 25;
      send_beat(char_beat(1'b1, 8'd0, 32'h0));
      repeat (CHAR_LIMIT + 3) begin
         send_beat(char_beat(1'b0, 8'($urandom_range(126, 32)), $urandom()));
      end
      send_beat(char_beat(1'b0, tclw_pkg::CH_NEWLINE, 32'h0));
      send_beat(char_beat(1'b1, 8'd0, 32'h0));
      wait_for_results();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // The receiver holds off for a long stretch while beats keep coming, so
   // the unit fills up and stalls its input.
   task automatic test_backpressure();
      apply_settings('{tclw_pkg::RST_WINDOW_WIDTH, tclw_pkg::RST_WINDOW_HEIGHT,
                       tclw_pkg::RST_MARGIN, tclw_pkg::RST_CELL_WIDTH,
                       tclw_pkg::RST_CELL_HEIGHT, tclw_pkg::RST_LINE_GAP,
                       tclw_pkg::RST_FIRST_PRINTABLE, tclw_pkg::RST_LAST_PRINTABLE});
      hold_request = HOLD_CYCLES;
      repeat (40) send_beat(random_text_beat());
      wait (hold_request == 0);
      wait_for_results();
   endtask

   // Random text under random settings, cycling through the idle patterns.
   task automatic test_random_stream();
      int phase;
      for (phase = 0; phase < RANDOM_PHASES; phase++) begin
         apply_settings(random_settings());
         case (phase % 4)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 45; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 45; end
            default: begin send_idle_pct = 25; stall_pct = 25; end
         endcase
         repeat (RANDOM_BEATS / RANDOM_PHASES) send_beat(random_text_beat());
      end
      wait_for_results();
      send_idle_pct = 0;
      stall_pct     = 0;
   endtask

   // ---------------------------------------------------------------------
   // Receiver, checker and watchdog
   // ---------------------------------------------------------------------

   // Random stalls, or one long hold-off when a test asks for it.
   initial begin
      forever begin
         if (hold_request > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold_request) @(posedge clock);
            hold_request = 0;
         end else begin
            rsp_stall <= ($urandom_range(99) < stall_pct);
            @(posedge clock);
         end
      end
   end

   function automatic void compare_field(string name, logic [31:0] expected,
                                         logic [31:0] actual);
      if (expected !== actual) begin
         error_count++;
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h",
                  $time, name, expected, actual);
      end
   endfunction

   // Each accepted result beat is matched against the oldest prediction.
   always @(posedge clock) begin
      tclw_pkg::rsp_type predicted;
      if (!reset && rsp_valid && !rsp_stall) begin
         status_seen[int'(rsp_payload.status)]++;
         if (pending_cells.size() == 0) begin
            error_count++;
            $display("%0t: unexpected result beat, status %0d",
                     $time, rsp_payload.status);
         end else begin
            predicted = pending_cells.pop_front();
            compare_field("status",     32'(predicted.status),
                          32'(rsp_payload.status));
            compare_field("pos_x",      32'(predicted.pos_x),
                          32'(rsp_payload.pos_x));
            compare_field("pos_y",      32'(predicted.pos_y),
                          32'(rsp_payload.pos_y));
            compare_field("glyph",      32'(predicted.glyph),
                          32'(rsp_payload.glyph));
            compare_field("cell_color", predicted.cell_color,
                          rsp_payload.cell_color);
            compare_field("slot_index", 32'(predicted.slot_index),
                          32'(rsp_payload.slot_index));
         end
      end
   end

   // Ends the run when no beat moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
      end
      if (quiet_cycles >= IDLE_LIMIT) begin
         $display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
         $display("tb: failure");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------
   initial begin
      layout_cfg = '{tclw_pkg::RST_WINDOW_WIDTH, tclw_pkg::RST_WINDOW_HEIGHT,
                     tclw_pkg::RST_MARGIN, tclw_pkg::RST_CELL_WIDTH,
                     tclw_pkg::RST_CELL_HEIGHT, tclw_pkg::RST_LINE_GAP,
                     tclw_pkg::RST_FIRST_PRINTABLE, tclw_pkg::RST_LAST_PRINTABLE};
      reset_pen_model();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_reset_defaults();
      test_wrap_and_clip();
      test_register_extremes();
      test_frame_limit();
      test_backpressure();
      test_random_stream();
      wait_for_results();

      $display("summary: %0d beats over %0d register settings, %0d errors",
               beats_sent, settings_applied, error_count);
      $display("summary: %0d drawn, %0d newline, %0d dropped, %0d cleared",
               status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/tclw_pkg.sv
rtl/tclw_front.sv
rtl/tclw_queue.sv
rtl/tclw_back.sv
rtl/text_cell_layout_with_wrap_unit.sv
tb/sv/tb_top.sv
